// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Operation and status codes, controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package spq_pkg;
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_CHANGE  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // commands from the controller
    typedef struct packed {
        logic load;     // capture request fields
        logic do_ins;   // insert shift with captured fields
        logic do_rem;   // remove shift at head or at id match
        logic at_head;  // remove position is slot 0
        logic use_keep; // insert uses order kept from remove
        logic clr_out;  // zero extracted fields
        logic cap_out;  // capture head as extracted fields
    } t_cmd;

    // status back to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic found;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp: sorted slot array datapath
// Parallel compares per slot; one insert or one remove shift per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module spq_dp
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [15:0] i_id,
    input  wire logic [15:0] i_ord,
    input  wire logic [15:0] i_pri,
    output t_stat            o_stat,
    output logic [15:0]      o_id,
    output logic [15:0]      o_ord,
    output logic [15:0]      o_pri,
    output logic [4:0]       o_count
);
    localparam int CW = $clog2(DEPTH + 1);

    logic [15:0]        r_sid [DEPTH];
    logic [15:0]        r_sord[DEPTH];
    logic signed [15:0] r_spri[DEPTH];
    logic [CW-1:0]      r_cnt;
    logic [15:0]        r_id, r_ord, r_keep;
    logic signed [15:0] r_pri;
    logic [15:0]        r_oid, r_oord, r_opri;

    logic [DEPTH-1:0] w_valid, w_match, w_first, w_after, w_gt, w_ins;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_valid[i] = (CW'(i) < r_cnt);
            w_match[i] = w_valid[i] && (r_sid[i] == r_id);
            w_gt[i]    = w_valid[i] && (r_spri[i] > r_pri);
        end
        // w_after[i]: slot i lies at or beyond the first id match (or head)
        w_after[0] = i_cmd.at_head | w_match[0];
        for (int i = 1; i < DEPTH; i++)
            w_after[i] = w_after[i-1] | w_match[i];
        w_first = w_after & ~{w_after[DEPTH-2:0], 1'b0};
        // sorted, so gt is a suffix of the valid run
        w_ins = w_gt;
    end

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.found = |w_match;
    assign o_id    = r_oid;
    assign o_ord   = r_oord;
    assign o_pri   = r_opri;
    assign o_count = 5'(r_cnt);

    logic [15:0] w_nord;
    assign w_nord = i_cmd.use_keep ? r_keep : r_ord;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id  <= i_id;
            r_ord <= i_ord;
            r_pri <= i_pri;
        end
        if (i_cmd.clr_out) begin
            r_oid <= '0; r_oord <= '0; r_opri <= '0;
        end else if (i_cmd.cap_out) begin
            r_oid <= r_sid[0]; r_oord <= r_sord[0]; r_opri <= r_spri[0];
        end
        if (i_cmd.do_rem) begin
            for (int i = 0; i < DEPTH; i++)
                if (w_first[i]) r_keep <= r_sord[i];
            for (int i = 0; i < DEPTH - 1; i++)
                if (w_after[i]) begin
                    r_sid[i]  <= r_sid[i+1];
                    r_sord[i] <= r_sord[i+1];
                    r_spri[i] <= r_spri[i+1];
                end
        end else if (i_cmd.do_ins) begin
            // slot 0 takes the new entry when it is the insert point or empty
            if (w_ins[0] || !w_valid[0]) begin
                r_sid[0]  <= r_id;
                r_sord[0] <= w_nord;
                r_spri[0] <= r_pri;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (w_ins[i-1]) begin
                    // shift up, including into the first free slot
                    r_sid[i]  <= r_sid[i-1];
                    r_sord[i] <= r_sord[i-1];
                    r_spri[i] <= r_spri[i-1];
                end else if (w_ins[i] || (!w_valid[i] && w_valid[i-1])) begin
                    r_sid[i]  <= r_id;
                    r_sord[i] <= w_nord;
                    r_spri[i] <= r_pri;
                end
            end
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.do_rem) begin
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.do_ins) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl: request sequencer
// Accepts a request, issues remove/insert shifts, presents the result.
// ----------------------------------------------------------------------------
`default_nettype none
module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_op,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            o_valid,
    input  wire logic       i_taken,
    output logic [1:0]      o_status
);
    typedef enum logic [1:0] { S_IDLE, S_EXEC, S_INS } t_state;
    t_state     r_state;
    logic [1:0] r_op;
    logic       r_ovalid;
    logic [1:0] r_status;

    logic w_acc;
    assign o_ready  = i_rst_n && (r_state == S_IDLE) && (!r_ovalid || i_taken);
    assign w_acc    = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_status = r_status;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = w_acc;
        unique case (r_state)
            S_IDLE: ;
            S_EXEC: begin
                unique case (r_op)
                    OP_INSERT: o_cmd.do_ins = !i_stat.full;
                    OP_EXTRACT: begin
                        o_cmd.do_rem  = !i_stat.empty;
                        o_cmd.at_head = 1'b1;
                        o_cmd.cap_out = 1'b1;
                        o_cmd.clr_out = i_stat.empty;
                    end
                    default: o_cmd.do_rem = i_stat.found;
                endcase
                if (r_op != OP_EXTRACT) o_cmd.clr_out = 1'b1;
            end
            S_INS: begin
                o_cmd.do_ins   = 1'b1;
                o_cmd.use_keep = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_taken) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    r_op    <= i_op;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    unique case (r_op)
                        OP_INSERT:  r_status <= i_stat.full  ? ST_FULL : ST_OK;
                        OP_EXTRACT: r_status <= i_stat.empty ? ST_MISS : ST_OK;
                        default:    r_status <= i_stat.found ? ST_OK : ST_MISS;
                    endcase
                    if (r_op == OP_CHANGE && i_stat.found) begin
                        r_state <= S_INS;
                    end else begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                    end
                end
                S_INS: begin
                    r_state  <= S_IDLE;
                    r_ovalid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept as a sorted slot list
// Smallest signed priority first; equal priorities leave in insertion order.
// A request is captured in S_IDLE and executed in S_EXEC (a change adds S_INS),
// one slot-array shift per cycle; a new request is accepted only in S_IDLE,
//   once the previous result has been taken.
// Reset: synchronous active-low i_rst_n empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[1:0], entry_id[17:2], arrival_order[33:18], new_priority[49:34]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], out_id[17:2], out_order[33:18], out_priority[49:34],
    // is_empty[50], entry_count[55:51]
    output logic [55:0]      m_axis_tdata
);
    t_cmd       w_cmd;
    t_stat      w_stat;
    logic [15:0] w_id, w_ord, w_pri;
    logic [4:0]  w_cnt;
    logic [1:0]  w_status;

    spq_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tdata[1:0]),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_valid (m_axis_tvalid),
        .i_taken (m_axis_tvalid & m_axis_tready),
        .o_status(w_status)
    );

    spq_dp #(.DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd  (w_cmd),
        .i_id   (s_axis_tdata[17:2]),
        .i_ord  (s_axis_tdata[33:18]),
        .i_pri  (s_axis_tdata[49:34]),
        .o_stat (w_stat),
        .o_id   (w_id),
        .o_ord  (w_ord),
        .o_pri  (w_pri),
        .o_count(w_cnt)
    );

    assign m_axis_tdata = {w_cnt, w_stat.empty, w_pri, w_ord, w_id, w_status};
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for sorted_priority_queue
// Drives insert/extract/remove/change requests over the input stream, keeps a
// sorted-list model of the queue and checks every response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
    import spq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int MAX_CYCLE = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow queue, slot 0 most urgent
    logic [15:0]        q_id  [DEPTH];
    logic [15:0]        q_ord [DEPTH];
    logic signed [15:0] q_pri [DEPTH];
    int                 q_cnt = 0;

    logic [55:0] resp_q [$];
    int  errors = 0;
    int  n_resp = 0;
    int  n_full = 0, n_miss = 0, n_chg = 0;
    int  cycles = 0;
    bit  src_idle_on = 1'b1;
    bit  snk_idle_on = 1'b1;
    bit  snk_hold = 1'b0;
    bit  snk_long = 1'b0;
    int  sent = 0;

    function automatic void q_put(logic [15:0] id, logic [15:0] ord,
                                  logic signed [15:0] pri);
        int pos;
        pos = 0;
        while (pos < q_cnt && q_pri[pos] <= pri) pos++;
        for (int i = q_cnt; i > pos; i--) begin
            q_id[i] = q_id[i-1]; q_ord[i] = q_ord[i-1]; q_pri[i] = q_pri[i-1];
        end
        q_id[pos] = id; q_ord[pos] = ord; q_pri[pos] = pri;
        q_cnt++;
    endfunction

    function automatic void q_take(int pos);
        for (int i = pos; i + 1 < q_cnt; i++) begin
            q_id[i] = q_id[i+1]; q_ord[i] = q_ord[i+1]; q_pri[i] = q_pri[i+1];
        end
        q_cnt--;
    endfunction

    // applies one request to the shadow queue, returns the packed response
    function automatic logic [55:0] queue_apply(t_op op, logic [15:0] id,
                                                logic [15:0] ord,
                                                logic signed [15:0] pri);
        logic [1:0]  st;
        logic [15:0] oid, oord, opri, keep;
        int          pos;
        st = ST_OK; oid = '0; oord = '0; opri = '0;
        case (op)
            OP_INSERT: begin
                if (q_cnt >= DEPTH) st = ST_FULL;
                else q_put(id, ord, pri);
            end
            OP_EXTRACT: begin
                if (q_cnt == 0) st = ST_MISS;
                else begin
                    oid = q_id[0]; oord = q_ord[0]; opri = q_pri[0];
                    q_take(0);
                end
            end
            default: begin
                pos = -1;
                for (int i = q_cnt - 1; i >= 0; i--) if (q_id[i] == id) pos = i;
                if (pos < 0) st = ST_MISS;
                else begin
                    keep = q_ord[pos];
                    q_take(pos);
                    if (op == OP_CHANGE) q_put(id, keep, pri);
                end
            end
        endcase
        if (st == ST_FULL) n_full++;
        if (st == ST_MISS) n_miss++;
        return {5'(q_cnt), q_cnt == 0, opri, oord, oid, st};
    endfunction

    // sends one request; expectation recorded at acceptance
    task automatic send_req(t_op op, logic [15:0] id, logic [15:0] ord,
                            logic signed [15:0] pri);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, pri, ord, id, op};
        do @(posedge i_clk); while (!s_axis_tready);
        resp_q.push_back(queue_apply(op, id, ord, pri));
        if (op == OP_CHANGE) n_chg++;
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // picks an id that is likely held, so remove/change mostly hit
    function automatic logic [15:0] pick_id();
        if (q_cnt > 0 && $urandom_range(0, 4) != 0)
            return q_id[$urandom_range(0, q_cnt - 1)];
        return 16'($urandom_range(0, 7));
    endfunction

    // response checker
    always @(posedge i_clk) begin
        logic [55:0] exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_resp++;
            if (resp_q.size() == 0) begin
                $display("%0t: unexpected response %h", $time, m_axis_tdata);
                errors++;
            end else begin
                exp_w = resp_q.pop_front();
                if (exp_w[1:0] !== m_axis_tdata[1:0])
                    $display("%0t: status exp %0d got %0d", $time, exp_w[1:0],
                             m_axis_tdata[1:0]);
                if (exp_w[17:2] !== m_axis_tdata[17:2])
                    $display("%0t: out_id exp %h got %h", $time, exp_w[17:2],
                             m_axis_tdata[17:2]);
                if (exp_w[33:18] !== m_axis_tdata[33:18])
                    $display("%0t: out_order exp %h got %h", $time, exp_w[33:18],
                             m_axis_tdata[33:18]);
                if (exp_w[49:34] !== m_axis_tdata[49:34])
                    $display("%0t: out_priority exp %h got %h", $time,
                             exp_w[49:34], m_axis_tdata[49:34]);
                if (exp_w[50] !== m_axis_tdata[50])
                    $display("%0t: is_empty exp %b got %b", $time, exp_w[50],
                             m_axis_tdata[50]);
                if (exp_w[55:51] !== m_axis_tdata[55:51])
                    $display("%0t: entry_count exp %0d got %0d", $time,
                             exp_w[55:51], m_axis_tdata[55:51]);
                if (exp_w !== m_axis_tdata) errors++;
            end
        end
    end

    // receiver: random stall bursts, or a long hold when requested
    always @(posedge i_clk) begin
        if (snk_hold || snk_long) m_axis_tready <= 1'b0;
        else if (snk_idle_on && $urandom_range(0, 5) == 0) m_axis_tready <= 1'b0;
        else m_axis_tready <= 1'b1;
    end

    always begin
        int n;
        @(posedge i_clk);
        if (snk_idle_on && !snk_hold && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            snk_hold <= 1'b1;
            repeat (n) @(posedge i_clk);
            snk_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_directed();
        send_req(OP_EXTRACT, 16'h0, 16'h0, 16'sh0);        // extract when empty
        send_req(OP_REMOVE, 16'h5, 16'h0, 16'sh0);         // remove absent id
        send_req(OP_CHANGE, 16'h5, 16'h0, 16'sh0);         // change absent id
        send_req(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'sh7FFF);
        send_req(OP_INSERT, 16'h0000, 16'h0000, 16'sh8000);
        send_req(OP_INSERT, 16'h1111, 16'h0001, 16'sh0);
        send_req(OP_INSERT, 16'h1111, 16'h0002, 16'sh0);    // duplicate id, tie
        send_req(OP_CHANGE, 16'h1111, 16'h0, 16'sh0);       // reinsert after tie
        send_req(OP_REMOVE, 16'h1111, 16'h0, 16'sh0);
        for (int i = 0; i < 13; i++)                        // fill to full
            send_req(OP_INSERT, 16'(i + 32), 16'(i), 16'(i % 3));
        send_req(OP_INSERT, 16'hABCD, 16'h1234, 16'sh1);    // insert when full
        send_req(OP_CHANGE, 16'hFFFF, 16'h0, -16'sd5);      // change on full
        send_req(OP_EXTRACT, 16'h0, 16'h0, 16'sh0);
        drain();
    endtask

    task automatic test_random(int n_items);
        int   r;
        t_op  op;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            op = r < 40 ? OP_INSERT : r < 65 ? OP_EXTRACT : r < 80 ? OP_REMOVE
                : OP_CHANGE;
            send_req(op, op == OP_INSERT ? 16'($urandom) : pick_id(),
                     16'($urandom),
                     $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4)));
        end
        drain();
    endtask

    // receiver held off while requests keep coming, so the block back-pressures
    task automatic test_backpressure();
        fork
            begin
                snk_idle_on = 1'b0;
                force_hold();
            end
            for (int k = 0; k < 20; k++)
                send_req($urandom_range(0, 1) ? OP_INSERT : OP_EXTRACT,
                         16'($urandom), 16'($urandom), 16'($urandom));
        join
        drain();
        snk_idle_on = 1'b1;
    endtask

    task automatic force_hold();
        int n;
        n = 0;
        @(posedge i_clk);
        snk_long <= 1'b1;
        while (n < 200) begin
            @(posedge i_clk);
            n++;
        end
        snk_long <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(330);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        test_random(80);
        $display("covered %0d requests, %0d responses: %0d full drops, %0d misses,",
                 sent, n_resp, n_full, n_miss);
        $display("%0d priority changes, one long receiver hold", n_chg);
        if (errors == 0 && resp_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
